FILE: rtl/sdb_pkg.sv
// Shared types and constants for the switch debouncer.
// Used by the interfaces, the register block, the core and the top level.
package sdb_pkg;

   localparam int TimeWidth      = 32;
   localparam int IntervalWidth  = 16;
   localparam int SampleWidth    = 10;
   localparam int CsrIndexWidth  = 3;
   localparam int CsrDataWidth   = 16;

   typedef enum logic [1:0] {
      MODE_LOCK_OUT = 2'd0,
      MODE_PROMPT   = 2'd1,
      MODE_STABLE   = 2'd2
   } mode_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      REG_DEBOUNCE_MODE    = 3'd0,
      REG_INTERVAL_MS      = 3'd1,
      REG_USE_ANALOG       = 3'd2,
      REG_ANALOG_THRESHOLD = 3'd3,
      REG_INITIAL_LEVEL    = 3'd4
   } reg_index_type;

   localparam logic [1:0]               ResetDebounceMode    = MODE_STABLE;
   localparam logic [IntervalWidth-1:0] ResetIntervalMs      = 16'd10;
   localparam logic                     ResetUseAnalog       = 1'b0;
   localparam logic [SampleWidth-1:0]   ResetAnalogThreshold = 10'd50;
   localparam logic                     ResetInitialLevel    = 1'b0;

   typedef struct packed {
      logic [1:0]               debounce_mode;
      logic [IntervalWidth-1:0] interval_ms;
      logic                     use_analog;
      logic [SampleWidth-1:0]   analog_threshold;
   } cfg_type;

endpackage

FILE: rtl/sdb_if.sv
// Handshake interfaces of the switch debouncer: sample beats, result beats
// and register writes. Depends on sdb_pkg for the field widths.
interface sdb_req_if;
   logic                               valid;
   logic                               ready;
   logic [sdb_pkg::TimeWidth-1:0]      now_ms;
   logic                               raw_level;
   logic [sdb_pkg::SampleWidth-1:0]    analog_sample;

   modport source (output valid, now_ms, raw_level, analog_sample, input ready);
   modport sink   (input valid, now_ms, raw_level, analog_sample, output ready);
endinterface

interface sdb_rsp_if;
   logic valid;
   logic ready;
   logic changed;
   logic level;
   logic rose;
   logic fell;

   modport source (output valid, changed, level, rose, fell, input ready);
   modport sink   (input valid, changed, level, rose, fell, output ready);
endinterface

interface sdb_csr_if;
   logic                                valid;
   logic                                ready;
   logic [sdb_pkg::CsrIndexWidth-1:0]   index;
   logic [sdb_pkg::CsrDataWidth-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/sdb_csr.sv
// Configuration registers of the switch debouncer.
// Depends on sdb_pkg and the sdb_csr_if interface.
module sdb_csr (
   input  logic            clock,
   input  logic            reset,
   sdb_csr_if.sink         csr_bus,
   output sdb_pkg::cfg_type cfg
);

   sdb_pkg::cfg_type cfg_ff;
   sdb_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   // The initial level register is accepted but not stored: reset always loads
   // the package default initial level, so it never needs storage.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            sdb_pkg::REG_DEBOUNCE_MODE:    cfg_in.debounce_mode    = csr_bus.data[1:0];
            sdb_pkg::REG_INTERVAL_MS:      cfg_in.interval_ms      = csr_bus.data;
            sdb_pkg::REG_USE_ANALOG:       cfg_in.use_analog       = csr_bus.data[0];
            sdb_pkg::REG_ANALOG_THRESHOLD:
               cfg_in.analog_threshold = csr_bus.data[sdb_pkg::SampleWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_mode    <= sdb_pkg::ResetDebounceMode;
         cfg_ff.interval_ms      <= sdb_pkg::ResetIntervalMs;
         cfg_ff.use_analog       <= sdb_pkg::ResetUseAnalog;
         cfg_ff.analog_threshold <= sdb_pkg::ResetAnalogThreshold;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/sdb_core.sv
// Debounce datapath: input register, level and timing state, result register.
// Depends on sdb_pkg and the sdb_req_if and sdb_rsp_if interfaces.
module sdb_core (
   input  logic             clock,
   input  logic             reset,
   input  sdb_pkg::cfg_type cfg,
   sdb_req_if.sink          req_bus,
   sdb_rsp_if.source        rsp_bus
);

   logic                              in_valid_ff;
   logic [sdb_pkg::TimeWidth-1:0]     in_now_ff;
   logic                              in_raw_ff;
   logic [sdb_pkg::SampleWidth-1:0]   in_sample_ff;

   logic                              stable_level_ff, stable_level_in;
   logic                              last_raw_ff, last_raw_in;
   logic [sdb_pkg::TimeWidth-1:0]     last_event_ff, last_event_in;

   logic rsp_valid_ff, rsp_changed_ff, rsp_level_ff;

   logic                          advance;
   logic                          step;
   logic                          cur;
   logic                          raw_diff;
   logic                          level_diff;
   logic                          elapsed;
   logic                          toggle;
   logic [sdb_pkg::TimeWidth-1:0] ref_time;
   logic [sdb_pkg::TimeWidth-1:0] delta;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !in_valid_ff || advance;
   assign step          = in_valid_ff && advance;

   always_comb begin
      cur        = cfg.use_analog ? (in_sample_ff > cfg.analog_threshold) : in_raw_ff;
      raw_diff   = cur != last_raw_ff;
      level_diff = cur != stable_level_ff;
      if (cfg.debounce_mode != sdb_pkg::MODE_LOCK_OUT
          && cfg.debounce_mode != sdb_pkg::MODE_PROMPT && raw_diff) begin
         ref_time = in_now_ff;
      end else begin
         ref_time = last_event_ff;
      end
      delta   = in_now_ff - ref_time;
      elapsed = delta >= {{(sdb_pkg::TimeWidth-sdb_pkg::IntervalWidth){1'b0}},
                          cfg.interval_ms};
      toggle  = elapsed && level_diff;

      case (cfg.debounce_mode)
         sdb_pkg::MODE_LOCK_OUT: begin
            last_raw_in   = last_raw_ff;
            last_event_in = toggle ? in_now_ff : last_event_ff;
         end
         sdb_pkg::MODE_PROMPT: begin
            last_raw_in   = cur;
            last_event_in = raw_diff ? in_now_ff : last_event_ff;
         end
         default: begin
            last_raw_in   = cur;
            last_event_in = (raw_diff || toggle) ? in_now_ff : last_event_ff;
         end
      endcase
      stable_level_in = toggle ? cur : stable_level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         stable_level_ff <= sdb_pkg::ResetInitialLevel;
         last_raw_ff     <= sdb_pkg::ResetInitialLevel;
         last_event_ff   <= '0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (step) begin
            stable_level_ff <= stable_level_in;
            last_raw_ff     <= last_raw_in;
            last_event_ff   <= last_event_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_now_ff    <= req_bus.now_ms;
         in_raw_ff    <= req_bus.raw_level;
         in_sample_ff <= req_bus.analog_sample;
      end
      if (step) begin
         rsp_changed_ff <= toggle;
         rsp_level_ff   <= stable_level_in;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.changed = rsp_changed_ff;
   assign rsp_bus.level   = rsp_level_ff;
   assign rsp_bus.rose    = rsp_changed_ff && rsp_level_ff;
   assign rsp_bus.fell    = rsp_changed_ff && !rsp_level_ff;

   a_level_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_level_ff == stable_level_ff)
      else $error("Result level differs from the debounced state.");

   a_change_flips_level: assert property (@(posedge clock) disable iff (reset)
      step && toggle |=> stable_level_ff != $past(stable_level_ff))
      else $error("A reported change did not flip the debounced level.");

   a_no_change_holds_level: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(stable_level_ff) && $stable(last_event_ff))
      else $error("Debounce state moved without a beat.");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> in_valid_ff && rsp_valid_ff && !rsp_bus.ready)
      else $error("Input stalled while the pipeline had room.");

endmodule

FILE: rtl/switch_debouncer_three_mode.sv
// Top level of the timed switch debouncer in three modes.
// Depends on sdb_pkg, the interfaces in sdb_if, sdb_csr and sdb_core.
//
// One sample beat is taken every clock while the input is not stalled. Its
// result beat passes through the input register and then the result register
// before it can leave. The input stalls only while both registers hold beats
// and the result side is not ready. The rate is set by the single path from
// the input register through the level compare, the 32-bit elapsed-time
// subtraction and the interval compare into the debounce state. Writes to
// initial_level are accepted but not stored, so after reset the debounced
// level always starts low. Register writes are taken every cycle.
module switch_debouncer_three_mode (
   input  logic      clock,
   input  logic      reset,
   sdb_req_if.sink   req_bus,
   sdb_rsp_if.source rsp_bus,
   sdb_csr_if.sink   csr_bus
);

   sdb_pkg::cfg_type cfg;

   sdb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   sdb_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule
